/* design/afs_pkg.sv */
package afs_pkg;

    localparam int MAX_DIM     = 256;
    localparam int WFB         = 8;             // fraction bits kept for the weights
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int DIM_W       = 9;
    localparam int POS_W       = 16 + DIM_W;    // Q9.16 position, size up to 2^DIM_W-1
    localparam int SHW         = POS_W + 1;
    localparam int ROW_W       = 2 * DIM_W;
    localparam int WW          = 2 * WFB + 1;   // corner weight, up to S*S
    localparam int AWW         = 2 * WFB + 8;   // weight times alpha and its sum
    localparam int NW          = 2 * WFB + 16;  // weight times alpha times color, summed
    localparam int QW          = 8;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [WFB:0]   S_ONE    = {1'b1, {WFB{1'b0}}};
    localparam logic [SHW-1:0] HALF_POS = SHW'(32768);
    localparam logic [AWW-1:0] HALF_SUM = AWW'(1) << (2 * WFB - 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [DIM_W-1:0] p0;
        logic [DIM_W-1:0] p1;
        logic [WFB-1:0]   frac;
    } t_axis;

    // one word in the queue between front and back
    typedef struct packed {
        logic              sample;
        logic              empty;
        logic [ADDR_W-1:0] idx;
        logic [31:0]       rgba;
        t_axis             ax;
        t_axis             ay;
    } t_work;

    typedef struct packed {
        logic                    valid;
        logic                    sample;
        logic                    empty;
        logic                    zero;
        logic [7:0]              alpha;
        logic [AWW-1:0]          d;
        logic [2:0][NW-1:0]      rem;
        logic [2:0][QW-1:0]      q;
    } t_div;

    // wrap position to the two neighbor texels and the sub-texel fraction
    function automatic t_axis axis_split(input logic [POS_W-1:0] pos,
                                         input logic [DIM_W-1:0] size);
        logic [SHW-1:0]   shifted;
        logic [DIM_W:0]   whole;
        logic [DIM_W:0]   whole_m1;
        t_axis            a;
        shifted  = {1'b0, pos} + HALF_POS;
        whole    = shifted[SHW-1:16];
        whole_m1 = whole - (DIM_W + 1)'(1);
        a.frac   = shifted[15 -: WFB];
        if (whole == '0) begin
            a.p0 = size - DIM_W'(1);
            a.p1 = '0;
        end else begin
            a.p0 = whole_m1[DIM_W-1:0];
            a.p1 = (whole >= {1'b0, size}) ? '0 : whole[DIM_W-1:0];
        end
        return a;
    endfunction

endpackage

/* design/afs_ram.sv */
module afs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/afs_front.sv */
module afs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [afs_pkg::ADDR_W-1:0]     i_texel_index,
    input  logic [31:0]                    i_rgba,
    input  logic signed [31:0]             i_coord_u,
    input  logic signed [31:0]             i_coord_v,
    input  logic [afs_pkg::DIM_W-1:0]      i_width,
    input  logic [afs_pkg::DIM_W-1:0]      i_height,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output afs_pkg::t_work                 o_q_data
);
    import afs_pkg::*;

    logic              f_adv;
    logic              r_f1_valid;
    logic              r_f1_sample;
    logic              r_f1_empty;
    logic [ADDR_W-1:0] r_f1_idx;
    logic [31:0]       r_f1_rgba;
    logic [POS_W-1:0]  r_f1_posu;
    logic [POS_W-1:0]  r_f1_posv;
    logic              r_f2_valid;
    t_work             r_f2_item;
    t_work             n_f2_item;

    assign f_adv      = !r_f2_valid || !i_q_full;
    assign o_in_stall = !f_adv;
    assign o_q_push   = r_f2_valid && !i_q_full;
    assign o_q_data   = r_f2_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (f_adv) begin
            r_f1_valid <= i_in_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    // stage 1: scale the wrapped fractions by the texture size
    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_f1_sample <= (i_op == OP_SAMPLE);
            r_f1_empty  <= (i_width == '0) || (i_height == '0);
            r_f1_idx    <= i_texel_index;
            r_f1_rgba   <= i_rgba;
            r_f1_posu   <= POS_W'({{DIM_W{1'b0}}, i_coord_u[15:0]} * {16'b0, i_width});
            r_f1_posv   <= POS_W'({{DIM_W{1'b0}}, i_coord_v[15:0]} * {16'b0, i_height});
            r_f2_item   <= n_f2_item;
        end
    end

    always_comb begin
        n_f2_item.sample = r_f1_sample;
        n_f2_item.empty  = r_f1_empty;
        n_f2_item.idx    = r_f1_idx;
        n_f2_item.rgba   = r_f1_rgba;
        n_f2_item.ax     = axis_split(r_f1_posu, i_width);
        n_f2_item.ay     = axis_split(r_f1_posv, i_height);
    end
endmodule

/* design/afs_fifo.sv */
module afs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  afs_pkg::t_work i_data,
    input  logic           i_pop,
    output afs_pkg::t_work o_data,
    output logic           o_full,
    output logic           o_empty
);
    import afs_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_work           r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

/* design/afs_div.sv */
module afs_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  afs_pkg::t_div i_st,
    output afs_pkg::t_div o_st
);
    import afs_pkg::*;

    t_div r_st [QW];

    // restoring division, one quotient bit per stage, MSB first
    for (genvar k = 0; k < QW; k++) begin : g_st
        t_div          src;
        t_div          n_st;
        logic [NW-1:0] dsh;

        if (k == 0) begin : g_first
            assign src = i_st;
        end else begin : g_rest
            assign src = r_st[k-1];
        end

        assign dsh = NW'(src.d) << (QW - 1 - k);

        always_comb begin
            n_st = src;
            for (int c = 0; c < 3; c++) begin
                if (src.rem[c] >= dsh) begin
                    n_st.rem[c]          = src.rem[c] - dsh;
                    n_st.q[c][QW-1-k]    = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_st = r_st[QW-1];
endmodule

/* design/afs_back.sv */
module afs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  afs_pkg::t_work             i_q_data,
    output logic                       o_q_pop,
    input  logic [afs_pkg::DIM_W-1:0]  i_width,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_blue,
    output logic [7:0]                 o_out_alpha
);
    import afs_pkg::*;

    logic                adv;

    logic                r_b1_valid;
    t_work               r_b1_item;
    logic [ROW_W-1:0]    r_b1_rowa;
    logic [ROW_W-1:0]    r_b1_rowb;
    logic [WW-1:0]       r_b1_wt [4];
    logic [WW-1:0]       n_b1_wt [4];
    logic [WFB:0]        nfx;
    logic [WFB:0]        nfy;
    logic [WFB:0]        efx;
    logic [WFB:0]        efy;

    logic [ADDR_W-1:0]   raddr [4];
    logic                ram_we;
    logic                ram_re;
    logic [31:0]         rdata [4];

    logic                r_b2_valid;
    logic                r_b2_sample;
    logic                r_b2_empty;
    logic [WW-1:0]       r_b2_wt [4];

    logic                r_b3_valid;
    logic                r_b3_sample;
    logic                r_b3_empty;
    logic [AWW-1:0]      r_b3_aw [4];
    logic [23:0]         r_b3_col [4];

    logic                r_b4_valid;
    logic                r_b4_sample;
    logic                r_b4_empty;
    logic [NW-1:0]       r_b4_nc [4][3];
    logic [AWW-1:0]      r_b4_awsum;
    logic [AWW-1:0]      n_b4_awsum;

    t_div                r_b5;
    t_div                n_b5;
    logic [AWW-1:0]      alpha_rnd;
    t_div                div_out;

    logic                r_out_valid;
    logic [7:0]          r_out_red;
    logic [7:0]          r_out_green;
    logic [7:0]          r_out_blue;
    logic [7:0]          r_out_alpha;

    // the whole back pipeline moves unless a result sits stalled at the output
    assign adv     = !r_out_valid || !i_out_stall;
    assign o_q_pop = adv && !i_q_empty;

    // B0: row offsets and corner weights
    assign efx = {1'b0, i_q_data.ax.frac};
    assign efy = {1'b0, i_q_data.ay.frac};
    assign nfx = S_ONE - efx;
    assign nfy = S_ONE - efy;

    always_comb begin
        n_b1_wt[0] = WW'(nfx * nfy);
        n_b1_wt[1] = WW'(efx * nfy);
        n_b1_wt[2] = WW'(nfx * efy);
        n_b1_wt[3] = WW'(efx * efy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
            r_b5.valid <= 1'b0;
        end else if (adv) begin
            r_b1_valid <= !i_q_empty;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
            r_b5       <= n_b5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1_item <= i_q_data;
            r_b1_rowa <= ROW_W'(i_q_data.ay.p0 * i_width);
            r_b1_rowb <= ROW_W'(i_q_data.ay.p1 * i_width);
            r_b1_wt   <= n_b1_wt;
        end
    end

    // B1: store access; a load writes every copy, a sample reads one corner per copy
    assign ram_we   = adv && r_b1_valid && !r_b1_item.sample;
    assign ram_re   = adv && r_b1_valid && r_b1_item.sample;
    assign raddr[0] = ADDR_W'(r_b1_rowa + ROW_W'(r_b1_item.ax.p0));
    assign raddr[1] = ADDR_W'(r_b1_rowa + ROW_W'(r_b1_item.ax.p1));
    assign raddr[2] = ADDR_W'(r_b1_rowb + ROW_W'(r_b1_item.ax.p0));
    assign raddr[3] = ADDR_W'(r_b1_rowb + ROW_W'(r_b1_item.ax.p1));

    for (genvar i = 0; i < 4; i++) begin : g_copy
        afs_ram #(
            .WIDTH (32),
            .DEPTH (STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we),
            .i_waddr (r_b1_item.idx),
            .i_wdata (r_b1_item.rgba),
            .i_re    (ram_re),
            .i_raddr (raddr[i]),
            .o_rdata (rdata[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b2_sample <= r_b1_item.sample;
            r_b2_empty  <= r_b1_item.empty;
            r_b2_wt     <= r_b1_wt;
        end
    end

    // B2: weight times alpha
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b3_sample <= r_b2_sample;
            r_b3_empty  <= r_b2_empty;
            for (int i = 0; i < 4; i++) begin
                r_b3_aw[i]  <= AWW'(r_b2_wt[i] * rdata[i][31:24]);
                r_b3_col[i] <= rdata[i][23:0];
            end
        end
    end

    // B3: per-corner color products and the weight sum
    always_comb begin
        n_b4_awsum = '0;
        for (int i = 0; i < 4; i++) begin
            n_b4_awsum = n_b4_awsum + r_b3_aw[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b4_sample <= r_b3_sample;
            r_b4_empty  <= r_b3_empty;
            r_b4_awsum  <= n_b4_awsum;
            for (int i = 0; i < 4; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_b4_nc[i][c] <= NW'(r_b3_aw[i] * r_b3_col[i][8*c +: 8]);
                end
            end
        end
    end

    // B4: dividends with the half-divisor rounding term, alpha rounding
    assign alpha_rnd = r_b4_awsum + HALF_SUM;

    always_comb begin
        n_b5.valid  = r_b4_valid;
        n_b5.sample = r_b4_sample;
        n_b5.empty  = r_b4_empty;
        n_b5.zero   = (r_b4_awsum == '0);
        n_b5.alpha  = alpha_rnd[2*WFB +: 8];
        n_b5.d      = r_b4_awsum;
        n_b5.q      = '0;
        for (int c = 0; c < 3; c++) begin
            n_b5.rem[c] = r_b4_nc[0][c] + r_b4_nc[1][c] + r_b4_nc[2][c] + r_b4_nc[3][c]
                        + NW'(r_b4_awsum >> 1);
        end
    end

    afs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_st    (r_b5),
        .o_st    (div_out)
    );

    // loads drop out here; samples land in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= div_out.valid && div_out.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (div_out.empty) begin
                r_out_red   <= 8'd0;
                r_out_green <= 8'd0;
                r_out_blue  <= 8'd0;
                r_out_alpha <= 8'd255;
            end else begin
                r_out_red   <= div_out.zero ? 8'd0 : div_out.q[0];
                r_out_green <= div_out.zero ? 8'd0 : div_out.q[1];
                r_out_blue  <= div_out.zero ? 8'd0 : div_out.q[2];
                r_out_alpha <= div_out.alpha;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;
endmodule

/* design/alpha_weighted_bilinear_sampler.sv */
// channel   direction  handshake                word
// in        to block   i_in_valid / o_in_stall  op, texel index, load RGBA, coord u/v
// out       from block o_out_valid / i_out_stall filtered RGBA, one per sample
// cfg       to block   i_cfg_valid / o_cfg_ready register index, data
//
// One word per cycle sustained while the output is not stalled; loads and samples may be mixed freely.
// A sample passes 2 front stages, the queue, 5 back stages, 8 divider stages
// and the output register. Four copies of the texel store give the
// four corner reads in one cycle.
// Reset is synchronous and clears control only; the texel store is not cleared.
// A stalled output freezes the back end; the 4-word queue lets the front keep taking words.
module alpha_weighted_bilinear_sampler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [15:0]           i_texel_index,
    input  logic [7:0]            i_load_red,
    input  logic [7:0]            i_load_green,
    input  logic [7:0]            i_load_blue,
    input  logic [7:0]            i_load_alpha,
    input  logic signed [31:0]    i_coord_u,
    input  logic signed [31:0]    i_coord_v,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_alpha,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [8:0]            i_cfg_data
);
    import afs_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] width_cl;
    logic [DIM_W-1:0] height_cl;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_work            q_wdata;
    t_work            q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign width_cl  = (r_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_width;
    assign height_cl = (r_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_height;

    afs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_texel_index (i_texel_index),
        .i_rgba        ({i_load_alpha, i_load_blue, i_load_green, i_load_red}),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .i_width       (width_cl),
        .i_height      (height_cl),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wdata)
    );

    afs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    afs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .i_width     (width_cl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );
endmodule

/* design/afs_chk.sv */
module afs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_op,
    input logic [15:0]        i_texel_index,
    input logic [7:0]         i_load_red,
    input logic [7:0]         i_load_green,
    input logic [7:0]         i_load_blue,
    input logic [7:0]         i_load_alpha,
    input logic signed [31:0] i_coord_u,
    input logic signed [31:0] i_coord_v,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [7:0]         o_out_red,
    input logic [7:0]         o_out_green,
    input logic [7:0]         o_out_blue,
    input logic [7:0]         o_out_alpha,
    input logic               i_cfg_valid,
    input logic               o_cfg_ready,
    input logic               i_cfg_index,
    input logic [8:0]         i_cfg_data
);
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_out_red, o_out_green, o_out_blue, o_out_alpha}))
        else $error("stalled result changed");
endmodule

bind alpha_weighted_bilinear_sampler afs_chk u_afs_chk (.*);
